// ----- design/text_console_writer_macros.svh -----
// assertion macros used by the text console writer sequencer
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// checked property, masked while reset is asserted
`define TCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked property, also active during reset
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tcw_pkg.sv -----
// shared types, codes and helpers of the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	localparam int CELL_W     = 16;
	localparam int COLOUR_W   = 4;
	localparam int CHAR_W     = 8;
	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 11;
	localparam int OUT_COL_W  = 7;
	localparam int OUT_ROW_W  = 5;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

	localparam logic [CHAR_W-1:0]   NEWLINE_CHAR = 8'h0A;
	localparam logic [CHAR_W-1:0]   BLANK_CHAR   = 8'h20;
	localparam logic [COLOUR_W-1:0] FG_RESET     = 4'd7;
	localparam logic [COLOUR_W-1:0] BG_RESET     = 4'd0;

	typedef struct packed {
		logic [COLOUR_W-1:0] bg;
		logic [COLOUR_W-1:0] fg;
	} colours_t;

	// attribute in the high byte, character in the low byte
	function automatic logic [CELL_W-1:0] make_cell(colours_t c, logic [CHAR_W-1:0] ch);
		return {c.bg, c.fg, ch};
	endfunction

	localparam logic [CELL_W-1:0] RESET_BLANK = {BG_RESET, FG_RESET, BLANK_CHAR};

endpackage

`default_nettype wire

// ----- design/tcw_mem.sv -----
// screen cell store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module tcw_mem #(
	parameter int DEPTH = 2000
) (
	input  wire                           clk,
	input  wire                           wr_en,
	input  wire  [$clog2(DEPTH)-1:0]      wr_addr,
	input  wire  [tcw_pkg::CELL_W-1:0]    wr_data,
	input  wire                           rd_en,
	input  wire  [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [tcw_pkg::CELL_W-1:0]    rd_data
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] cells_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cells_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= cells_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/tcw_ctrl.sv -----
// command sequencer: cursor, clear and scroll sweeps, result register
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_macros.svh"

module tcw_ctrl #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  tcw_pkg::colours_t                     colours,
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [tcw_pkg::S_DATA_W-1:0]          s_tdata,
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [tcw_pkg::M_DATA_W-1:0]          m_tdata,
	output logic                                  mem_wr_en,
	output logic [$clog2(COLUMNS*ROWS)-1:0]       mem_wr_addr,
	output logic [tcw_pkg::CELL_W-1:0]            mem_wr_data,
	output logic                                  mem_rd_en,
	output logic [$clog2(COLUMNS*ROWS)-1:0]       mem_rd_addr,
	input  wire  [tcw_pkg::CELL_W-1:0]            mem_rd_data
);
	import tcw_pkg::*;

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);

	localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] COLS_A       = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] BOTTOM_START = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(ROWS - 1);

	typedef enum logic [7:0] {
		S_INIT   = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_EXEC   = 8'b0000_0100,
		S_READ   = 8'b0000_1000,
		S_FILL   = 8'b0001_0000,
		S_SCROLL = 8'b0010_0000,
		S_SBLANK = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [FUNC_W-1:0]   func_q;
	logic [CHAR_W-1:0]   char_q;
	logic [IDX_W-1:0]    idx_q;
	logic [COL_W-1:0]    cur_col_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic [CELL_W-1:0]   value_q;
	logic                copy_s1;
	logic [ADDR_W-1:0]   waddr_s1;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic [ADDR_W-1:0]       cur_addr;
	logic [ADDR_W+IDX_W-1:0] idx_ext;
	logic                    idx_ok;
	logic                    is_newline;
	logic                    wrap;
	logic [COL_W+OUT_COL_W-1:0] col_ext;
	logic [ROW_W+OUT_ROW_W-1:0] row_ext;

	assign cur_addr   = ADDR_W'(cur_row_q * COLS_A) + ADDR_W'(cur_col_q);
	assign idx_ext    = (ADDR_W + IDX_W)'(idx_q);
	assign idx_ok     = 32'(idx_q) < 32'(CELL_COUNT);
	assign is_newline = char_q == NEWLINE_CHAR;
	assign wrap       = is_newline || (cur_col_q == COL_LAST);
	assign col_ext    = (COL_W + OUT_COL_W)'(cur_col_q);
	assign row_ext    = (ROW_W + OUT_ROW_W)'(cur_row_q);

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = ptr_q;
		mem_wr_data = make_cell(colours, BLANK_CHAR);
		mem_rd_en   = 1'b0;
		mem_rd_addr = ptr_q;
		if (copy_s1) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = waddr_s1;
			mem_wr_data = mem_rd_data;
		end else begin
			case (state_q)
				S_INIT: begin
					mem_wr_en   = 1'b1;
					mem_wr_data = RESET_BLANK;
				end
				S_FILL, S_SBLANK: begin
					mem_wr_en = 1'b1;
				end
				S_EXEC: begin
					if (func_q == FUNC_WRITE && !is_newline) begin
						mem_wr_en   = 1'b1;
						mem_wr_addr = cur_addr;
						mem_wr_data = make_cell(colours, char_q);
					end
				end
				default: begin
				end
			endcase
		end
		case (state_q)
			S_EXEC: begin
				if (func_q == FUNC_READ && idx_ok) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = idx_ext[ADDR_W-1:0];
				end
			end
			S_SCROLL: begin
				mem_rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			ptr_q      <= '0;
			copy_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (ptr_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
					ptr_q <= ptr_q + 1'b1;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					ptr_q   <= '0;
					state_q <= S_EMIT;
					case (func_q)
						FUNC_WRITE: begin
							if (!wrap) begin
								cur_col_q <= cur_col_q + 1'b1;
							end else begin
								cur_col_q <= '0;
								if (cur_row_q == ROW_LAST) begin
									ptr_q   <= COLS_A;
									state_q <= S_SCROLL;
								end else begin
									cur_row_q <= cur_row_q + 1'b1;
								end
							end
						end
						FUNC_CLEAR: begin
							state_q <= S_FILL;
						end
						FUNC_READ: begin
							if (idx_ok) begin
								state_q <= S_READ;
							end
						end
						default: begin
						end
					endcase
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_FILL: begin
					if (ptr_q == LAST_CELL) begin
						state_q <= S_EMIT;
					end
					ptr_q <= ptr_q + 1'b1;
				end
				S_SCROLL: begin
					copy_s1 <= 1'b1;
					if (ptr_q == LAST_CELL) begin
						ptr_q   <= BOTTOM_START;
						state_q <= S_SBLANK;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_SBLANK: begin
					copy_s1 <= 1'b0;
					// the last copy still owns the write port while copy_s1 is set
					if (!copy_s1) begin
						if (ptr_q == LAST_CELL) begin
							state_q <= S_EMIT;
						end
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tdata[1:0];
			char_q <= s_tdata[9:2];
			idx_q  <= s_tdata[20:10];
		end
		if (state_q == S_EXEC) begin
			value_q <= '0;
		end else if (state_q == S_READ) begin
			value_q <= mem_rd_data;
		end
		if (state_q == S_SCROLL) begin
			waddr_s1 <= ptr_q - COLS_A;
		end
		if (state_q == S_EMIT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {4'b0, row_ext[OUT_ROW_W-1:0], col_ext[OUT_COL_W-1:0], value_q};
		end
	end

	`TCW_ASSERT(a_no_same_entry, (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr), "write and read hit the same cell")
	`TCW_ASSERT(a_result_from_emit, $rose(m_tvalid_q) |-> $past(state_q == S_EMIT), "result raised outside emit")
	`TCW_ASSERT(a_cursor_range, (cur_col_q <= COL_LAST) && (cur_row_q <= ROW_LAST), "cursor out of screen")
	`TCW_ASSERT_ALWAYS(a_copy_only_scroll, copy_s1 |-> (state_q == S_SCROLL || state_q == S_SBLANK), "copy pending outside scroll")

endmodule

`default_nettype wire

// ----- design/text_console_writer.sv -----
// text console writer top level: colour registers, sequencer and cell store
// on the way to result valid a scroll adds the SCROLL and SBLANK sweeps and a clear the FILL
// sweep, a read of a screen cell READ; one item at a time, s_tready comes back with result
// valid; the sweeps run one cell a cycle through the single write port of the cell store
// reset clears cursor, resets colours at once, then a clearing pass over COLUMNS*ROWS cells
// fills the store with blanks while s_tready stays low; config writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// input items
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [tcw_pkg::S_DATA_W-1:0]      s_tdata,   // func, char_code, cell_index
	// result items
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [tcw_pkg::M_DATA_W-1:0]      m_tdata,   // cell_value, cursor_col, cursor_row
	// colour register writes
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [tcw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tcw_pkg::*;

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	colours_t            colours_q;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [CELL_W-1:0]   wr_data;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [CELL_W-1:0]   rd_data;

	// registers are always writable; new colours apply to later writes only
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colours_q.fg <= FG_RESET;
			colours_q.bg <= BG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FG:  colours_q.fg <= cfg_data[COLOUR_W-1:0];
				CFG_BG:  colours_q.bg <= cfg_data[COLOUR_W-1:0];
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	// sequencer owns the cursor, the sweeps and the result register
	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.colours     (colours_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mem_wr_en   (wr_en),
		.mem_wr_addr (wr_addr),
		.mem_wr_data (wr_data),
		.mem_rd_en   (rd_en),
		.mem_rd_addr (rd_addr),
		.mem_rd_data (rd_data)
	);

	// screen cells, row-major
	tcw_mem #(
		.DEPTH (CELL_COUNT)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

// ----- bench/tb_text_console_writer.sv -----
// self-checking bench for the text console writer: random and directed console ops
`timescale 1ns / 1ps

module tb_text_console_writer;
	import tcw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int IDX_TOP = (1 << IDX_W) - 1;

	// func code that neither writes nor moves the cursor, but still gives a result
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// register indexes past the colour pair, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	// one console op as it sits in s_tdata, func in the lowest bits
	typedef struct packed {
		logic [IDX_W-1:0]  cell_index;
		logic [CHAR_W-1:0] char_code;
		logic [FUNC_W-1:0] func;
	} console_op_t;

	// one result as it sits in m_tdata, cell_value in the lowest bits
	typedef struct packed {
		logic [OUT_ROW_W-1:0] cursor_row;
		logic [OUT_COL_W-1:0] cursor_col;
		logic [CELL_W-1:0]    cell_value;
	} cursor_report_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;   // func, char_code, cell_index
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;          // cell_value, cursor_col, cursor_row
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	text_console_writer #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ops waiting for the driver, and results the console should still send
	console_op_t    pending_ops[$];
	cursor_report_t expected_reports[$];
	console_op_t    shown_op;

	// idling knobs, percent of cycles
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;

	int mismatch_count = 0;

	// bench copy of the console: screen, cursor and colours
	logic [CELL_W-1:0]   screen_copy [CELLS];
	int                  col_now = 0;
	int                  row_now = 0;
	logic [COLOUR_W-1:0] fg_now;
	logic [COLOUR_W-1:0] bg_now;

	// attribute byte is bg in the high nibble, fg in the low nibble
	function automatic logic [CELL_W-1:0] coloured(logic [CHAR_W-1:0] ch);
		return {bg_now, fg_now, ch};
	endfunction

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen_copy[i] = coloured(BLANK_CHAR);
	endfunction

	// applies one op to the bench copy and returns the result it must produce
	function automatic cursor_report_t console_step(console_op_t op);
		cursor_report_t rep;
		logic           wrap;
		rep  = '0;
		wrap = 1'b0;
		case (op.func)
			FUNC_WRITE: begin
				// newline stores nothing, it only wraps
				if (op.char_code == NEWLINE_CHAR) begin
					wrap = 1'b1;
				end else begin
					screen_copy[row_now * COLUMNS + col_now] = coloured(op.char_code);
					col_now++;
					if (col_now >= COLUMNS)
						wrap = 1'b1;
				end
				if (wrap) begin
					col_now = 0;
					row_now++;
					// past the bottom row: scroll up one row, blank the bottom row
					if (row_now >= ROWS) begin
						for (int i = 0; i + COLUMNS < CELLS; i++)
							screen_copy[i] = screen_copy[i + COLUMNS];
						for (int i = CELLS - COLUMNS; i < CELLS; i++)
							screen_copy[i] = coloured(BLANK_CHAR);
						row_now = ROWS - 1;
					end
				end
			end
			FUNC_CLEAR: begin
				// cursor stays where it is
				blank_screen();
			end
			FUNC_READ: begin
				// reads past the screen give zero
				if (op.cell_index < CELLS)
					rep.cell_value = screen_copy[op.cell_index];
			end
			default: begin
			end
		endcase
		rep.cursor_col = OUT_COL_W'(col_now);
		rep.cursor_row = OUT_ROW_W'(row_now);
		return rep;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// driver: presents queued ops, predicts each one on its transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_reports.push_back(console_step(shown_op));
			// the current op is held until it transfers
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					shown_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= S_DATA_W'(shown_op);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks every result transfer against the oldest expectation
	always @(posedge clk) begin
		cursor_report_t got;
		cursor_report_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = cursor_report_t'(m_tdata[$bits(cursor_report_t)-1:0]);
				if (expected_reports.size() == 0) begin
					flag_mismatch($sformatf("result with nothing expected, tdata %h", m_tdata));
				end else begin
					want = expected_reports.pop_front();
					if (got.cell_value !== want.cell_value)
						flag_mismatch($sformatf("cell_value got %h expected %h",
							got.cell_value, want.cell_value));
					if (got.cursor_col !== want.cursor_col)
						flag_mismatch($sformatf("cursor_col got %0d expected %0d",
							got.cursor_col, want.cursor_col));
					if (got.cursor_row !== want.cursor_row)
						flag_mismatch($sformatf("cursor_row got %0d expected %0d",
							got.cursor_row, want.cursor_row));
				end
			end
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic queue_op(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx);
		console_op_t op;
		op.func       = func;
		op.char_code  = ch;
		op.cell_index = idx;
		pending_ops.push_back(op);
	endtask

	// one colour register write, the bench copy follows on the transfer
	task automatic write_colour_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_FG:  fg_now = data[COLOUR_W-1:0];
			CFG_BG:  bg_now = data[COLOUR_W-1:0];
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	// waits until every op has transferred and every result has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || s_tvalid || expected_reports.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// random ops, mostly in short runs that move the cursor down and across
	task automatic queue_random_ops(input int target);
		int                 added;
		int                 pick;
		int                 run;
		logic [IDX_W-1:0]   idx;
		added = 0;
		while (added < target) begin
			pick = $urandom_range(99);
			if (pick < 22) begin
				// newline burst, scrolls once the cursor sits on the bottom row
				run = $urandom_range(5, 1);
				repeat (run)
					queue_op(FUNC_WRITE, NEWLINE_CHAR, IDX_W'($urandom_range(IDX_TOP)));
				added += run;
			end else if (pick < 55) begin
				// short run of arbitrary bytes, a newline now and then
				run = $urandom_range(8, 1);
				repeat (run)
					queue_op(FUNC_WRITE, CHAR_W'($urandom_range(255)),
						IDX_W'($urandom_range(IDX_TOP)));
				added += run;
			end else if (pick < 58) begin
				// about a full line, so the cursor wraps at the last column
				run = $urandom_range(COLUMNS + 4, COLUMNS - 4);
				repeat (run)
					queue_op(FUNC_WRITE, CHAR_W'($urandom_range(126, 33)),
						IDX_W'($urandom_range(IDX_TOP)));
				added += run;
			end else if (pick < 83) begin
				// reads, biased to the rows that get written and the screen end
				run = $urandom_range(4, 1);
				repeat (run) begin
					case ($urandom_range(3))
						0:       idx = IDX_W'($urandom_range(3 * COLUMNS - 1));
						1:       idx = IDX_W'($urandom_range(CELLS - 1, CELLS - 3 * COLUMNS));
						2:       idx = IDX_W'($urandom_range(CELLS + 8, CELLS - 8));
						default: idx = IDX_W'($urandom_range(IDX_TOP));
					endcase
					queue_op(FUNC_READ, CHAR_W'($urandom_range(255)), idx);
				end
				added += run;
			end else if (pick < 88) begin
				queue_op(FUNC_CLEAR, CHAR_W'($urandom_range(255)),
					IDX_W'($urandom_range(IDX_TOP)));
				added++;
			end else if (pick < 93) begin
				// unused func, changes nothing but still gives a result; not counted
				queue_op(FUNC_UNUSED, CHAR_W'($urandom_range(255)),
					IDX_W'($urandom_range(IDX_TOP)));
			end else begin
				// noise: any func, any fields
				queue_op(FUNC_W'($urandom_range(3)), CHAR_W'($urandom_range(255)),
					IDX_W'($urandom_range(IDX_TOP)));
				added++;
			end
		end
	endtask

	initial begin
		fg_now = FG_RESET;
		bg_now = BG_RESET;
		blank_screen();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed ops in reset colours; the driver waits out the clearing pass
		queue_op(FUNC_READ, 8'h00, IDX_W'(0));
		queue_op(FUNC_READ, 8'hFF, IDX_W'(CELLS - 1));
		queue_op(FUNC_READ, 8'h00, IDX_W'(CELLS));     // first index past the screen
		queue_op(FUNC_READ, 8'h00, IDX_W'(IDX_TOP));
		queue_op(FUNC_WRITE, 8'h41, IDX_W'(IDX_TOP));
		queue_op(FUNC_WRITE, 8'h00, IDX_W'(0));
		queue_op(FUNC_WRITE, 8'hFF, IDX_W'(0));
		queue_op(FUNC_READ, 8'h00, IDX_W'(0));
		queue_op(FUNC_READ, 8'h00, IDX_W'(1));
		queue_op(FUNC_READ, 8'h00, IDX_W'(2));
		queue_op(FUNC_WRITE, NEWLINE_CHAR, IDX_W'(0));
		queue_op(FUNC_UNUSED, 8'hFF, IDX_W'(IDX_TOP));
		queue_op(FUNC_WRITE, 8'h42, IDX_W'(0));
		queue_op(FUNC_READ, 8'h00, IDX_W'(COLUMNS));
		queue_op(FUNC_CLEAR, 8'hFF, IDX_W'(IDX_TOP));
		queue_op(FUNC_READ, 8'h00, IDX_W'(0));
		queue_op(FUNC_READ, 8'h00, IDX_W'(COLUMNS));
		queue_op(FUNC_READ, 8'h00, IDX_W'(CELLS - 1));
		wait_idle();

		// extremes with stray upper bits, and a dropped write to a spare index
		write_colour_reg(CFG_FG, 8'hF0);
		write_colour_reg(CFG_BG, 8'h0F);
		write_colour_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(255)));
		// no idling
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		queue_random_ops(75);
		wait_idle();

		// random colours; old cells keep their attribute
		write_colour_reg(CFG_FG, CFG_DATA_W'($urandom_range(255)));
		write_colour_reg(CFG_BG, CFG_DATA_W'($urandom_range(255)));
		write_colour_reg(CFG_SPARE_HI, 8'hFF);
		tx_idle_pct  = 73;
		rx_stall_pct = 0;
		queue_random_ops(75);
		wait_idle();

		write_colour_reg(CFG_FG, 8'hFF);
		write_colour_reg(CFG_BG, 8'hFF);
		tx_idle_pct  = 0;
		rx_stall_pct = 73;
		queue_random_ops(75);
		wait_idle();

		write_colour_reg(CFG_FG, 8'h00);
		write_colour_reg(CFG_BG, 8'h00);
		write_colour_reg(CFG_SPARE_LO, 8'h00);
		tx_idle_pct  = 17;
		rx_stall_pct = 17;
		queue_random_ops(75);
		wait_idle();

		// room for any stray result after the last one
		repeat (64) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// run limit, well beyond a run where every op sweeps the whole screen
	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
